// ===== sv/fsws_pkg.sv =====
package fsws_pkg;

    // block sizing
    localparam int SAMPLE_BITS      = 8;
    localparam int MAX_HARMONICS    = 1024;
    localparam int SINE_TABLE_DEPTH = 1024;

    // field widths
    localparam int N_W        = 16;
    localparam int STEP_W     = 32;
    localparam int MODE_W     = 2;
    localparam int HC_W       = 11;
    localparam int VAL_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // fixed point: sine entries are Q2.28, weights Q28
    localparam int Q_FRAC = 28;
    localparam int SIN_W  = Q_FRAC + 2;
    localparam int W_W    = Q_FRAC + 1;

    // table address widths
    localparam int SA_W = $clog2(SINE_TABLE_DEPTH);
    localparam int HA_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
    localparam int WA_W = HA_W + 1;

    // harmonic counter must hold the last harmonic plus the stride
    localparam int HN_W  = $clog2(MAX_HARMONICS + 3);
    localparam int CNT_W = (HN_W > HC_W) ? HN_W : HC_W;

    // accumulator: the weighted sum stays well below 2^33
    localparam int ACC_W = 34;
    localparam int SUM_W = 32;

    // output scaling
    localparam int FULL_M1 = (1 << SAMPLE_BITS) - 1;
    localparam int PM_W    = SUM_W + SAMPLE_BITS;
    localparam int Y_W     = SAMPLE_BITS + 2;
    localparam int DIV_K   = Y_W + 3;
    localparam int DIV_M   = ((1 << DIV_K) + 4) / 5;
    localparam int M_W     = DIV_K - 1;
    localparam int PQ_W    = Y_W + M_W;
    localparam int VW      = (Y_W + 1 > VAL_W) ? Y_W + 1 : VAL_W;

    localparam logic [STEP_W-1:0] PHASE_STEP_RESET = 32'd107374182;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HARM_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_SINE   = 2'd0,
        MODE_SAW    = 2'd1,
        MODE_SQUARE = 2'd2,
        MODE_TRI    = 2'd3
    } t_wave_mode;

    // microcode sequencing
    localparam int UCODE_DEPTH = 8;
    typedef logic [2:0] t_upc;

    localparam t_upc UPC_IDLE  = 3'd0;
    localparam t_upc UPC_SETUP = 3'd1;
    localparam t_upc UPC_LOOP  = 3'd2;
    localparam t_upc UPC_DRAIN = 3'd3;

    typedef enum logic [2:0] {
        C_NEXT    = 3'd0,
        C_ALWAYS  = 3'd1,
        C_NOSTART = 3'd2,
        C_MORE    = 3'd3,
        C_EMPTY   = 3'd4
    } t_cond;

    typedef struct packed {
        logic setup;
        logic issue;
        logic post_mul;
        logic post_div;
        logic emit;
    } t_ctrl;

    typedef struct packed {
        t_ctrl ctrl;
        t_cond cond;
        t_upc  target;
    } t_uword;

    typedef struct packed {
        logic more;
        logic empty;
    } t_stat;

    localparam t_ctrl CTRL_NONE  = '{default: 1'b0};
    localparam t_ctrl CTRL_SETUP = '{setup: 1'b1, default: 1'b0};
    localparam t_ctrl CTRL_ISSUE = '{issue: 1'b1, default: 1'b0};
    localparam t_ctrl CTRL_PMUL  = '{post_mul: 1'b1, default: 1'b0};
    localparam t_ctrl CTRL_PDIV  = '{post_div: 1'b1, default: 1'b0};
    localparam t_ctrl CTRL_EMIT  = '{emit: 1'b1, default: 1'b0};

    // program: wait, set up, harmonic loop, drain two stages, scale, emit
    localparam t_uword UCODE [UCODE_DEPTH] = '{
        '{ctrl: CTRL_NONE,  cond: C_NOSTART, target: UPC_IDLE},
        '{ctrl: CTRL_SETUP, cond: C_EMPTY,   target: UPC_DRAIN},
        '{ctrl: CTRL_ISSUE, cond: C_MORE,    target: UPC_LOOP},
        '{ctrl: CTRL_NONE,  cond: C_NEXT,    target: UPC_IDLE},
        '{ctrl: CTRL_NONE,  cond: C_NEXT,    target: UPC_IDLE},
        '{ctrl: CTRL_PMUL,  cond: C_NEXT,    target: UPC_IDLE},
        '{ctrl: CTRL_PDIV,  cond: C_NEXT,    target: UPC_IDLE},
        '{ctrl: CTRL_EMIT,  cond: C_ALWAYS,  target: UPC_IDLE}
    };

endpackage

// ===== sv/fsws_sine_rom.sv =====
module fsws_sine_rom (
    input  logic                                     i_clk,
    input  logic        [fsws_pkg::SA_W-1:0]         i_addr,
    output logic signed [fsws_pkg::SIN_W-1:0]        o_data
);

    typedef logic signed [fsws_pkg::SIN_W-1:0] t_sine_tab [fsws_pkg::SINE_TABLE_DEPTH];

    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam logic [63:0] HALF_PI  = 64'd1686629713;
    localparam logic [63:0] DEPTH64  = 64'(fsws_pkg::SINE_TABLE_DEPTH);
    localparam logic [63:0] MAG_ONE  = 64'd1 << fsws_pkg::Q_FRAC;

    // taylor series to x^15 on the angle folded into the first quadrant
    function automatic logic signed [fsws_pkg::SIN_W-1:0] sine_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic [63:0]        mag;
        logic signed [63:0] s;
        logic               neg;
        x   = (64'(k) * 64'd2 * PI_Q30) / DEPTH64;
        neg = 1'b0;
        if (x >= PI_Q30) begin
            neg = 1'b1;
            x   = x - PI_Q30;
        end
        if (x > HALF_PI) begin
            x = PI_Q30 - x;
        end
        x2 = (x * x) >> 30;
        s  = $signed(x);
        t  = x;
        t  = ((t * x2) >> 30) / 64'd6;
        s  = s - $signed(t);
        t  = ((t * x2) >> 30) / 64'd20;
        s  = s + $signed(t);
        t  = ((t * x2) >> 30) / 64'd42;
        s  = s - $signed(t);
        t  = ((t * x2) >> 30) / 64'd72;
        s  = s + $signed(t);
        t  = ((t * x2) >> 30) / 64'd110;
        s  = s - $signed(t);
        t  = ((t * x2) >> 30) / 64'd156;
        s  = s + $signed(t);
        t  = ((t * x2) >> 30) / 64'd210;
        s  = s - $signed(t);
        if (s < 0) begin
            s = '0;
        end
        // round half up from q30 to q28
        mag = ($unsigned(s) + 64'd2) >> 2;
        if (mag > MAG_ONE) begin
            mag = MAG_ONE;
        end
        return neg ? -fsws_pkg::SIN_W'(mag) : fsws_pkg::SIN_W'(mag);
    endfunction

    function automatic t_sine_tab build_tab();
        t_sine_tab tab;
        for (int k = 0; k < fsws_pkg::SINE_TABLE_DEPTH; k++) begin
            tab[k] = sine_entry(k);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_tab();

    // registered read
    always_ff @(posedge i_clk) begin
        o_data <= SINE_TAB[i_addr];
    end

endmodule

// ===== sv/fsws_wt_rom.sv =====
module fsws_wt_rom (
    input  logic                          i_clk,
    input  logic [fsws_pkg::WA_W-1:0]     i_addr,
    output logic [fsws_pkg::W_W-1:0]      o_data
);

    localparam int WT_DEPTH = 1 << fsws_pkg::WA_W;

    typedef logic [fsws_pkg::W_W-1:0] t_wt_tab [WT_DEPTH];

    // floor(2^28 / d) by long division
    function automatic logic [fsws_pkg::W_W-1:0] recip(input logic [31:0] d);
        logic [31:0]               rem;
        logic [fsws_pkg::W_W-1:0]  q;
        rem = '0;
        q   = '0;
        for (int b = fsws_pkg::Q_FRAC; b >= 0; b--) begin
            rem = {rem[30:0], (b == fsws_pkg::Q_FRAC)};
            if (rem >= d) begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // lower half: 1/i, upper half: 1/i^2, entry j holds harmonic j+1
    function automatic t_wt_tab build_tab();
        t_wt_tab     tab;
        logic [31:0] h;
        for (int a = 0; a < WT_DEPTH; a++) begin
            h = 32'((a % (WT_DEPTH / 2)) + 1);
            if (a >= WT_DEPTH / 2) begin
                tab[a] = recip(h * h);
            end else begin
                tab[a] = recip(h);
            end
        end
        return tab;
    endfunction

    localparam t_wt_tab WT_TAB = build_tab();

    // registered read
    always_ff @(posedge i_clk) begin
        o_data <= WT_TAB[i_addr];
    end

endmodule

// ===== sv/fsws_seq.sv =====
module fsws_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  fsws_pkg::t_stat   i_stat,
    output logic              o_busy,
    output fsws_pkg::t_ctrl   o_ctrl
);

    fsws_pkg::t_upc   r_upc;
    fsws_pkg::t_upc   n_upc;
    fsws_pkg::t_uword uw;
    logic             jump;

    // control word of the current step
    assign uw = fsws_pkg::UCODE[r_upc];

    // jump condition
    always_comb begin
        case (uw.cond)
            fsws_pkg::C_NEXT:    jump = 1'b0;
            fsws_pkg::C_ALWAYS:  jump = 1'b1;
            fsws_pkg::C_NOSTART: jump = !i_start;
            fsws_pkg::C_MORE:    jump = i_stat.more;
            fsws_pkg::C_EMPTY:   jump = i_stat.empty;
            default:             jump = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        n_upc = jump ? uw.target : fsws_pkg::t_upc'(r_upc + 3'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= fsws_pkg::UPC_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_busy = (r_upc != fsws_pkg::UPC_IDLE);
    assign o_ctrl = uw.ctrl;

endmodule

// ===== sv/fsws_datapath.sv =====
module fsws_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_accept,
    input  logic        [fsws_pkg::N_W-1:0]       i_sample_index,
    input  fsws_pkg::t_ctrl                       i_ctrl,
    input  fsws_pkg::t_wave_mode                  i_wave_mode,
    input  logic        [fsws_pkg::HC_W-1:0]      i_harm_count,
    input  logic        [fsws_pkg::STEP_W-1:0]    i_phase_step,
    output fsws_pkg::t_stat                       o_stat,
    output logic                                  o_valid,
    output logic signed [fsws_pkg::VAL_W-1:0]     o_sample_value,
    output logic                                  o_clipped
);

    localparam int CNT_W  = fsws_pkg::CNT_W;
    localparam int STEP_W = fsws_pkg::STEP_W;
    localparam int N_W    = fsws_pkg::N_W;
    localparam int W_W    = fsws_pkg::W_W;
    localparam int SIN_W  = fsws_pkg::SIN_W;
    localparam int ACC_W  = fsws_pkg::ACC_W;
    localparam int SUM_W  = fsws_pkg::SUM_W;
    localparam int PM_W   = fsws_pkg::PM_W;
    localparam int Y_W    = fsws_pkg::Y_W;
    localparam int PQ_W   = fsws_pkg::PQ_W;
    localparam int VW     = fsws_pkg::VW;

    localparam logic signed [ACC_W-1:0] SUM_MAX =
        $signed({{(ACC_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] SUM_MIN =
        $signed({{(ACC_W-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}});

    logic [N_W-1:0]           r_n;
    logic [STEP_W-1:0]        r_phase;
    logic [STEP_W-1:0]        r_inc;
    logic [CNT_W-1:0]         r_i;
    logic                     r_v1;
    logic                     r_neg1;
    logic                     r_v2;
    logic                     r_sgn2;
    logic [W_W-1:0]           r_term;
    logic signed [ACC_W-1:0]  r_acc;
    logic [PM_W-1:0]          r_pm;
    logic                     r_neg;
    logic [PQ_W-1:0]          r_pq;
    logic                     r_valid;

    logic [CNT_W-1:0]              hc;
    logic [CNT_W-1:0]              cnt_sat;
    logic [CNT_W-1:0]              cnt_eff;
    logic                          stride2;
    logic                          is_tri;
    logic [CNT_W-1:0]              i_next;
    logic [N_W+STEP_W-1:0]         base_full;
    logic [STEP_W-1:0]             base;
    logic [fsws_pkg::SA_W-1:0]     sin_addr;
    logic [fsws_pkg::WA_W-1:0]     wt_addr;
    logic signed [SIN_W-1:0]       sin_q;
    logic [W_W-1:0]                wt_q;
    logic [W_W-1:0]                sin_mag;
    logic [2*W_W-1:0]              prod;
    logic signed [ACC_W-1:0]       term_ext;
    logic [SUM_W-1:0]              sum_u;
    logic                          sum_neg;
    logic [SUM_W-1:0]              sum_mag;
    logic [Y_W-1:0]                y;
    logic [Y_W-1:0]                q;
    logic [Y_W-1:0]                qc;
    logic                          clip;
    logic [VW-1:0]                 vv;
    logic [VW-1:0]                 val;

    // harmonic range and stride for the mode
    always_comb begin
        hc      = CNT_W'(i_harm_count);
        cnt_sat = (hc > CNT_W'(fsws_pkg::MAX_HARMONICS)) ?
                  CNT_W'(fsws_pkg::MAX_HARMONICS) : hc;
        cnt_eff = (i_wave_mode == fsws_pkg::MODE_SINE) ? CNT_W'(1) : cnt_sat;
        stride2 = (i_wave_mode == fsws_pkg::MODE_SQUARE) ||
                  (i_wave_mode == fsws_pkg::MODE_TRI);
        is_tri  = (i_wave_mode == fsws_pkg::MODE_TRI);
        i_next  = r_i + (stride2 ? CNT_W'(2) : CNT_W'(1));
    end

    assign o_stat.more  = (i_next <= cnt_eff);
    assign o_stat.empty = (cnt_eff == '0);

    // phase of the fundamental for this sample
    assign base_full = {{STEP_W{1'b0}}, r_n} * {{N_W{1'b0}}, i_phase_step};
    assign base      = base_full[STEP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_n <= i_sample_index;
        end
    end

    // phase and harmonic number walk
    always_ff @(posedge i_clk) begin
        if (i_ctrl.setup) begin
            r_phase <= base;
            r_inc   <= stride2 ? {base[STEP_W-2:0], 1'b0} : base;
            r_i     <= CNT_W'(1);
        end else if (i_ctrl.issue) begin
            r_phase <= r_phase + r_inc;
            r_i     <= i_next;
        end
    end

    // table lookups
    assign sin_addr = r_phase[STEP_W-1 -: fsws_pkg::SA_W];
    assign wt_addr  = {is_tri, fsws_pkg::HA_W'(r_i - CNT_W'(1))};

    fsws_sine_rom u_sine_rom (
        .i_clk  (i_clk),
        .i_addr (sin_addr),
        .o_data (sin_q)
    );

    fsws_wt_rom u_wt_rom (
        .i_clk  (i_clk),
        .i_addr (wt_addr),
        .o_data (wt_q)
    );

    // stage 1 tags alongside the table reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctrl.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg1 <= is_tri && (r_i[1:0] == 2'b11);
    end

    // stage 2: magnitude times weight
    assign sin_mag = sin_q[SIN_W-1] ? W_W'(-sin_q) : W_W'(sin_q);
    assign prod    = {{W_W{1'b0}}, sin_mag} * {{W_W{1'b0}}, wt_q};

    always_ff @(posedge i_clk) begin
        r_term <= W_W'(prod >> fsws_pkg::Q_FRAC);
        r_sgn2 <= sin_q[SIN_W-1] ^ r_neg1;
    end

    // stage 3: accumulate
    assign term_ext = $signed({{(ACC_W-W_W){1'b0}}, r_term});

    always_ff @(posedge i_clk) begin
        if (i_ctrl.setup) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_sgn2 ? r_acc - term_ext : r_acc + term_ext;
        end
    end

    // saturate to q4.28 and take the magnitude
    always_comb begin
        if (r_acc > SUM_MAX) begin
            sum_u = SUM_MAX[SUM_W-1:0];
        end else if (r_acc < SUM_MIN) begin
            sum_u = SUM_MIN[SUM_W-1:0];
        end else begin
            sum_u = r_acc[SUM_W-1:0];
        end
        sum_neg = sum_u[SUM_W-1];
        sum_mag = sum_neg ? (~sum_u + 1'b1) : sum_u;
    end

    // scale by full scale, then divide by 20 or 40 as shift and times 1/5
    assign y = (i_wave_mode == fsws_pkg::MODE_SAW) ? Y_W'(r_pm >> 31) : Y_W'(r_pm >> 30);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.post_mul) begin
            r_pm  <= {{fsws_pkg::SAMPLE_BITS{1'b0}}, sum_mag} * PM_W'(fsws_pkg::FULL_M1);
            r_neg <= sum_neg;
        end
        if (i_ctrl.post_div) begin
            r_pq <= PQ_W'(y) * PQ_W'(fsws_pkg::DIV_M);
        end
    end

    // quotient, clip, sign
    always_comb begin
        q    = Y_W'(r_pq >> fsws_pkg::DIV_K);
        clip = (q >= Y_W'(1 << fsws_pkg::SAMPLE_BITS));
        qc   = clip ? Y_W'(fsws_pkg::FULL_M1) : q;
        vv   = VW'(qc);
        val  = r_neg ? (~vv + 1'b1) : vv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctrl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            o_sample_value <= $signed(val[fsws_pkg::VAL_W-1:0]);
            o_clipped      <= clip;
        end
    end

    assign o_valid = r_valid;

endmodule

// ===== sv/fourier_series_waveform_synth.sv =====
// channel   | signals                                          | direction
// ----------+--------------------------------------------------+----------
// request   | start, busy, i_sample_index                      | in
// result    | o_valid, o_sample_value, o_clipped               | out
// config    | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | in
//
// a request is taken when start is high and busy low; the result strobe o_valid
// follows the harmonic loop, the drain and the scaling steps; sine runs a single
// harmonic and a count of zero skips the loop. the harmonic loop issues one
// table read and one weight multiply per cycle, so its length sets the wait.
// reset is synchronous, active low; the tables are constant, so no clearing pass.
// the receiver cannot stall: each result is shown for one cycle.
module fourier_series_waveform_synth (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic        [fsws_pkg::N_W-1:0]        i_sample_index,
    output logic                                   o_valid,
    output logic signed [fsws_pkg::VAL_W-1:0]      o_sample_value,
    output logic                                   o_clipped,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic        [fsws_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [fsws_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic signed [fsws_pkg::VAL_W-1:0] CLIP_POS =
        fsws_pkg::VAL_W'(fsws_pkg::FULL_M1);
    localparam logic signed [fsws_pkg::VAL_W-1:0] CLIP_NEG =
        fsws_pkg::VAL_W'(-fsws_pkg::FULL_M1);

    fsws_pkg::t_wave_mode               r_wave_mode;
    logic [fsws_pkg::HC_W-1:0]          r_harm_count;
    logic [fsws_pkg::STEP_W-1:0]        r_phase_step;
    logic                               accept;
    fsws_pkg::t_ctrl                    ctrl;
    fsws_pkg::t_stat                    stat;

    // configuration registers, writable only while idle
    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_mode  <= fsws_pkg::MODE_SINE;
            r_harm_count <= fsws_pkg::HC_W'(1);
            r_phase_step <= fsws_pkg::PHASE_STEP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                fsws_pkg::REG_WAVE_MODE:  r_wave_mode  <= fsws_pkg::t_wave_mode'(i_cfg_data[1:0]);
                fsws_pkg::REG_HARM_COUNT: r_harm_count <= i_cfg_data[fsws_pkg::HC_W-1:0];
                fsws_pkg::REG_PHASE_STEP: r_phase_step <= i_cfg_data[fsws_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign accept = start && !busy;

    // microcode sequencer
    fsws_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_ctrl  (ctrl)
    );

    // phase, table, multiply-accumulate and scaling datapath
    fsws_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_sample_index (i_sample_index),
        .i_ctrl         (ctrl),
        .i_wave_mode    (r_wave_mode),
        .i_harm_count   (r_harm_count),
        .i_phase_step   (r_phase_step),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_sample_value (o_sample_value),
        .o_clipped      (o_clipped)
    );

    // a taken request keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // a result ends the program, so the block is idle while it is shown
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // one strobe per request, never two in a row
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // a clipped sample sits at the limit
    a_clip_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |-> (o_sample_value == CLIP_POS || o_sample_value == CLIP_NEG))
        else $error("clip flag without limit value");

endmodule
